[sv/bsa_pkg.sv]
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared widths, codes and default sizes for the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int KIND_W   = 2;
    localparam int SLOT_W   = 8;
    localparam int STATUS_W = 2;
    localparam int LIVE_W   = 9;

    localparam int DEF_NUM_WORDS = 4;
    localparam int DEF_WORD_BITS = 64;

    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;

endpackage

[sv/bsa_bitmap_mem.sv]
// ----------------------------------------------------------------------------
// bsa_bitmap_mem
// Bitmap word store with one write port and one registered read port.
// A per-word valid bit makes a word that was never written read as all free.
// ----------------------------------------------------------------------------
module bsa_bitmap_mem
    import bsa_pkg::*;
#(
    parameter int NUM_WORDS = DEF_NUM_WORDS,
    parameter int WORD_BITS = DEF_WORD_BITS,
    localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [WORD_BITS-1:0] i_wr_data,
    input  logic [AW-1:0]        i_rd_addr,
    output logic [WORD_BITS-1:0] o_rd_word
);

    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_vld;
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rdata <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rvld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_word = r_rvld ? r_rdata : '0;

endmodule

[sv/bitmap_slot_allocator_top.sv]
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_top
// Lowest-free-slot allocator over a bitmap, with a high-water count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request item: kind and
//   slot_index. Output channel (o_out_valid / i_out_stall) returns exactly one
//   result item per request: status, granted_index, fresh and live_count.
//   A request is taken only while the sequencer is idle. Allocate and flush
//   walk the bitmap store one word per cycle through its single registered
//   read port. A flush and an allocate on a full pool walk every word of the
//   store; an allocate that finds a free slot in word k, and a release of a
//   slot in word k, stop at word k. An unknown slot or the unused kind skips
//   the scan entirely. After the last scan step the sequencer moves to its
//   output state, and from there the result is copied into the output
//   register as soon as that register is free.
//   The result sits in an output register; a new request is accepted while
//   it waits, and the sequencer only holds at its last step if the previous
//   result has still not been taken by a stalling receiver.
//   Synchronous reset marks every slot free and clears the high-water count
//   at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_top
    import bsa_pkg::*;
#(
    parameter int NUM_WORDS = DEF_NUM_WORDS,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [SLOT_W-1:0]   i_slot_index,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_granted_index,
    output logic                o_fresh,
    output logic [LIVE_W-1:0]   o_live_count
);

    localparam int AW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BW    = $clog2(WORD_BITS);
    localparam int POOL  = NUM_WORDS * WORD_BITS;
    localparam int SW    = $clog2(POOL + 1);
    localparam int CMP_W = (SW > SLOT_W) ? SW : SLOT_W;
    localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);
    localparam logic [SW-1:0] POOL_SW   = SW'(POOL);
    localparam logic [SW-1:0] WB_SW     = SW'(WORD_BITS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_cw, n_cw;
    logic [SW-1:0]       r_cbase, n_cbase;
    logic [SW-1:0]       r_end, n_end;
    logic [SW-1:0]       r_hw, n_hw;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [SLOT_W-1:0]   r_idx, n_idx;
    logic [STATUS_W-1:0] r_hst, n_hst;
    logic [SLOT_W-1:0]   r_hgr, n_hgr;
    logic                r_hfr, n_hfr;

    logic                r_ovld;
    logic [STATUS_W-1:0] r_ost;
    logic [SLOT_W-1:0]   r_ogr;
    logic                r_ofr;
    logic [LIVE_W-1:0]   r_olive;

    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;
    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] free_bits;
    logic                 found;
    logic [BW-1:0]        pos;
    logic [SW-1:0]        end_w;
    logic [SW-1:0]        alloc_idx;
    logic                 rel_hit;
    logic [BW-1:0]        rel_bit;
    logic                 is_last;
    logic                 out_free;
    logic                 accept;

    bsa_bitmap_mem #(
        .NUM_WORDS (NUM_WORDS),
        .WORD_BITS (WORD_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_cw),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_word (word)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_ovld || !i_out_stall;
    assign is_last    = (r_cw == LAST_WORD);

    // The next word is fetched while the current one is examined.
    assign rd_addr = (r_state == S_SCAN && !is_last) ? AW'(r_cw + AW'(1)) :
                     (r_state == S_SCAN) ? r_cw : '0;

    // Shared word unit: lowest free bit, release hit test, word end.
    always_comb begin
        free_bits = ~word;
        found     = |free_bits;
        pos       = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                pos = BW'(b);
            end
        end
        end_w     = r_cbase + WB_SW;
        alloc_idx = r_cbase + SW'(pos);
        rel_hit   = CMP_W'(r_idx) < CMP_W'(end_w);
        rel_bit   = BW'(CMP_W'(r_idx) - CMP_W'(r_cbase));
    end

    always_comb begin
        n_state = r_state;
        n_cw    = r_cw;
        n_cbase = r_cbase;
        n_end   = r_end;
        n_hw    = r_hw;
        n_kind  = r_kind;
        n_idx   = r_idx;
        n_hst   = r_hst;
        n_hgr   = r_hgr;
        n_hfr   = r_hfr;
        wr_en   = 1'b0;
        wr_data = word;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind  = i_kind;
                    n_idx   = i_slot_index;
                    n_cw    = '0;
                    n_cbase = '0;
                    n_end   = '0;
                    n_hst   = ST_OK;
                    n_hgr   = '0;
                    n_hfr   = 1'b0;
                    priority if (i_kind == KIND_ALLOC || i_kind == KIND_FLUSH) begin
                        n_state = S_SCAN;
                    end else if (i_kind == KIND_RELEASE) begin
                        // The high-water count never exceeds the pool size,
                        // so this also rejects slots beyond the pool.
                        if (CMP_W'(i_slot_index) >= CMP_W'(r_hw)) begin
                            n_hst   = ST_UNKNOWN;
                            n_state = S_OUT;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_SCAN: begin
                priority if (r_kind == KIND_ALLOC) begin
                    if (found) begin
                        wr_en   = 1'b1;
                        wr_data = word | ({{(WORD_BITS-1){1'b0}}, 1'b1} << pos);
                        n_hgr   = SLOT_W'(alloc_idx);
                        if (alloc_idx >= r_hw) begin
                            n_hfr = 1'b1;
                            n_hw  = alloc_idx + SW'(1);
                        end
                        n_state = S_OUT;
                    end else if (is_last) begin
                        n_hst   = ST_FULL;
                        n_state = S_OUT;
                    end else begin
                        n_cw    = AW'(r_cw + AW'(1));
                        n_cbase = end_w;
                    end
                end else if (r_kind == KIND_RELEASE) begin
                    if (rel_hit) begin
                        wr_en   = 1'b1;
                        wr_data = word & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << rel_bit);
                        n_state = S_OUT;
                    end else if (is_last) begin
                        n_state = S_OUT;
                    end else begin
                        n_cw    = AW'(r_cw + AW'(1));
                        n_cbase = end_w;
                    end
                end else begin
                    // Flush: remember the end of the last word with a used slot.
                    if (word != '0) begin
                        n_end = end_w;
                    end
                    if (is_last) begin
                        if (n_end < r_hw) begin
                            n_hw = n_end;
                        end
                        n_state = S_OUT;
                    end else begin
                        n_cw    = AW'(r_cw + AW'(1));
                        n_cbase = end_w;
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hw    <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hw    <= n_hw;
            if (r_state == S_OUT && out_free) begin
                r_ovld <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cw    <= n_cw;
        r_cbase <= n_cbase;
        r_end   <= n_end;
        r_kind  <= n_kind;
        r_idx   <= n_idx;
        r_hst   <= n_hst;
        r_hgr   <= n_hgr;
        r_hfr   <= n_hfr;
        if (r_state == S_OUT && out_free) begin
            r_ost   <= r_hst;
            r_ogr   <= r_hgr;
            r_ofr   <= r_hfr;
            r_olive <= LIVE_W'(r_hw);
        end
    end

    assign o_out_valid     = r_ovld;
    assign o_status        = r_ost;
    assign o_granted_index = r_ogr;
    assign o_fresh         = r_ofr;
    assign o_live_count    = r_olive;

    a_hw_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hw <= POOL_SW)
        else $error("high-water count beyond pool size");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("sequencer idle right after an accepted item");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovld) |-> $past(r_state == S_OUT))
        else $error("result appeared without a finishing step");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cw <= LAST_WORD))
        else $error("scan word index out of range");

    a_flush_no_raise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_kind == KIND_FLUSH) |=> (r_hw <= $past(r_hw)))
        else $error("flush raised the high-water count");

endmodule
